FILE: rtl/tmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared widths, register indexes, sample phases and the cached move plan of
// the trapezoidal motion profile generator.
// ----------------------------------------------------------------------------
package tmp_pkg;

	localparam int WORD_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int MAG_W   = WORD_W - 1;
	localparam int TIME_W  = WORD_W + 2;
	localparam int DWORD_W = 2 * WORD_W;
	localparam int IDX_W   = 3;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_START_POS = 3'd0,
		REG_END_POS   = 3'd1,
		REG_MAX_VEL   = 3'd2,
		REG_MAX_ACC   = 3'd3,
		REG_SYNC_DUR  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_END   = 3'd1,
		PH_ACC   = 3'd2,
		PH_CRU   = 3'd3,
		PH_DEC   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [WORD_W-1:0]  h;
		logic [WORD_W-1:0]  ta;
		logic [WORD_W-1:0]  tc;
		logic [TIME_W-1:0]  tf;
		logic [MAG_W-1:0]   pk;
		logic [MAG_W-1:0]   ea;
		logic [DWORD_W-1:0] dacc;
		logic [DWORD_W-1:0] ub;
		logic               moving;
		logic               neg;
	} plan_t;

endpackage
`default_nettype wire

FILE: rtl/tmp_plan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmp_plan
// Move planner: derives phase times, peak velocity, effective acceleration
// and direction from the registers, using one shared multiplier, a radix-2
// divider and a two-bits-per-step square root.
// ----------------------------------------------------------------------------
module tmp_plan import tmp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              restart,
	input  wire logic [WORD_W-1:0] start_position,
	input  wire logic [WORD_W-1:0] end_position,
	input  wire logic [MAG_W-1:0]  max_velocity,
	input  wire logic [MAG_W-1:0]  max_acceleration,
	input  wire logic [WORD_W-1:0] sync_duration,
	output plan_t                  plan,
	output logic                   plan_ok
);

	localparam int CNT_W = $clog2(DWORD_W + 1);

	typedef enum logic [19:0] {
		ST_START     = 20'h00001,
		ST_VV        = 20'h00002,
		ST_HA        = 20'h00004,
		ST_TRI_DIV   = 20'h00008,
		ST_SQRT      = 20'h00010,
		ST_TRI_MUL   = 20'h00020,
		ST_TRI_PK    = 20'h00040,
		ST_TRAP_DIV1 = 20'h00080,
		ST_TRAP_DIV2 = 20'h00100,
		ST_TF        = 20'h00200,
		ST_SY_MUL    = 20'h00400,
		ST_SY_DIV1   = 20'h00800,
		ST_SY_DIV2   = 20'h01000,
		ST_SY_DIV3   = 20'h02000,
		ST_FIN1      = 20'h04000,
		ST_FIN2      = 20'h08000,
		ST_FIN3      = 20'h10000,
		ST_FIN4      = 20'h20000,
		ST_FIN5      = 20'h40000,
		ST_DONE      = 20'h80000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	logic [WORD_W:0]    diff_c, mag_c;
	logic [WORD_W-1:0]  h_c;
	logic [MAG_W-1:0]   a_c, v_c;
	logic [TIME_W-1:0]  tf_c;
	logic [MAG_W-1:0]   v2_c, a2_c;
	logic [DWORD_W-1:0] tdiff_c;

	logic [WORD_W-1:0]  mul_x, mul_y;
	logic [DWORD_W-1:0] prod_q;

	logic               div_go, sq_go, done;
	logic [DWORD_W-1:0] div_num, div_den;
	logic [DWORD_W-1:0] div_n_q, div_d_q, div_r_q;
	logic [DWORD_W:0]   div_rs, div_rn;
	logic               div_ge;

	logic [DWORD_W-1:0] sq_x_q;
	logic [WORD_W+1:0]  sq_r_q;
	logic [WORD_W-1:0]  sq_root_q;
	logic [WORD_W+3:0]  sq_rs, sq_trial, sq_nx;
	logic               sq_ge;

	logic [WORD_W-1:0]  h_q, ta_q, tc_q, t_q;
	logic [MAG_W-1:0]   a_q, v_q, pk_q, ea_q;
	logic [TIME_W-1:0]  tf_q;
	logic [DWORD_W-1:0] vv_q, raw_q, p_q, lo_q, dacc_q, ub_q;
	logic               moving_q, neg_q;

	assign diff_c = {end_position[WORD_W-1], end_position}
		- {start_position[WORD_W-1], start_position};
	assign mag_c  = diff_c[WORD_W] ? (~diff_c + 1'b1) : diff_c;
	assign h_c    = mag_c[WORD_W-1:0];
	assign a_c    = (max_acceleration == '0) ? MAG_W'(1) : max_acceleration;
	assign v_c    = (max_velocity == '0) ? MAG_W'(1) : max_velocity;
	assign tf_c   = {1'b0, ta_q, 1'b0} + {2'b00, tc_q};
	assign v2_c   = (|div_n_q[DWORD_W-1:MAG_W]) ? MAG_MAX : div_n_q[MAG_W-1:0];
	assign a2_c   = v2_c;
	assign tdiff_c = div_n_q - raw_q;
	assign done   = (cnt_q == '0);

	assign div_rs = {div_r_q, div_n_q[DWORD_W-1]};
	assign div_ge = div_rs >= {1'b0, div_d_q};
	assign div_rn = div_ge ? (div_rs - {1'b0, div_d_q}) : div_rs;

	assign sq_rs    = {sq_r_q, sq_x_q[DWORD_W-1 -: 2]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign sq_ge    = sq_rs >= sq_trial;
	assign sq_nx    = sq_ge ? (sq_rs - sq_trial) : sq_rs;

	always_comb begin
		state_d = state_q;
		mul_x   = '0;
		mul_y   = '0;
		div_go  = 1'b0;
		div_num = '0;
		div_den = '0;
		sq_go   = 1'b0;
		case (state_q)
			ST_START: begin
				if (h_c == '0) begin
					state_d = ST_DONE;
				end else begin
					mul_x   = {1'b0, v_c};
					mul_y   = {1'b0, v_c};
					state_d = ST_VV;
				end
			end
			ST_VV: begin
				mul_x   = h_q;
				mul_y   = {1'b0, a_q};
				state_d = ST_HA;
			end
			ST_HA: begin
				div_go  = 1'b1;
				div_den = DWORD_W'(a_q);
				if (vv_q > prod_q) begin
					div_num = {h_q, {WORD_W{1'b0}}};
					state_d = ST_TRI_DIV;
				end else begin
					div_num = DWORD_W'({v_q, {FRAC_W{1'b0}}});
					state_d = ST_TRAP_DIV1;
				end
			end
			ST_TRI_DIV: begin
				if (done) begin
					sq_go   = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (done) state_d = ST_TRI_MUL;
			end
			ST_TRI_MUL: begin
				mul_x   = {1'b0, a_q};
				mul_y   = ta_q;
				state_d = ST_TRI_PK;
			end
			ST_TRI_PK: state_d = ST_TF;
			ST_TRAP_DIV1: begin
				if (done) begin
					div_go  = 1'b1;
					div_num = DWORD_W'({h_q, {FRAC_W{1'b0}}});
					div_den = DWORD_W'(v_q);
					state_d = ST_TRAP_DIV2;
				end
			end
			ST_TRAP_DIV2: begin
				if (done) state_d = ST_TF;
			end
			ST_TF: begin
				if (tf_c != '0 && {2'b00, t_q} > tf_c) begin
					mul_x   = ta_q;
					mul_y   = t_q;
					state_d = ST_SY_MUL;
				end else begin
					state_d = ST_FIN1;
				end
			end
			ST_SY_MUL: begin
				div_go  = 1'b1;
				div_num = prod_q;
				div_den = DWORD_W'(tf_q);
				state_d = ST_SY_DIV1;
			end
			ST_SY_DIV1: begin
				if (done) begin
					div_go  = 1'b1;
					div_num = DWORD_W'({h_q, {FRAC_W{1'b0}}});
					div_den = DWORD_W'(t_q - div_n_q[WORD_W-1:0]);
					state_d = ST_SY_DIV2;
				end
			end
			ST_SY_DIV2: begin
				if (done) begin
					if (ta_q != '0) begin
						div_go  = 1'b1;
						div_num = DWORD_W'({v2_c, {FRAC_W{1'b0}}});
						div_den = DWORD_W'(ta_q);
						state_d = ST_SY_DIV3;
					end else begin
						state_d = ST_FIN1;
					end
				end
			end
			ST_SY_DIV3: begin
				if (done) state_d = ST_FIN1;
			end
			ST_FIN1: begin
				mul_x   = {1'b0, ea_q};
				mul_y   = ta_q;
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				mul_x   = prod_q[WORD_W-1:0];
				mul_y   = ta_q;
				state_d = ST_FIN3;
			end
			ST_FIN3: begin
				mul_x   = p_q[DWORD_W-1:WORD_W];
				mul_y   = ta_q;
				state_d = ST_FIN4;
			end
			ST_FIN4: begin
				mul_x   = {1'b0, pk_q};
				mul_y   = tc_q;
				state_d = ST_FIN5;
			end
			ST_FIN5: state_d = ST_DONE;
			ST_DONE: state_d = ST_DONE;
			default: state_d = ST_START;
		endcase
		if (restart) state_d = ST_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (div_go) cnt_q <= CNT_W'(DWORD_W);
			else if (sq_go) cnt_q <= CNT_W'(WORD_W);
			else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;

		if (div_go) begin
			div_n_q <= div_num;
			div_d_q <= div_den;
			div_r_q <= '0;
		end else if (cnt_q != '0) begin
			div_n_q <= {div_n_q[DWORD_W-2:0], div_ge};
			div_r_q <= div_rn[DWORD_W-1:0];
		end

		if (sq_go) begin
			sq_x_q    <= div_n_q;
			sq_r_q    <= '0;
			sq_root_q <= '0;
		end else if (cnt_q != '0) begin
			sq_x_q    <= {sq_x_q[DWORD_W-3:0], 2'b00};
			sq_r_q    <= sq_nx[WORD_W+1:0];
			sq_root_q <= {sq_root_q[WORD_W-2:0], sq_ge};
		end

		case (state_q)
			ST_START: begin
				h_q      <= h_c;
				a_q      <= a_c;
				v_q      <= v_c;
				ea_q     <= a_c;
				t_q      <= sync_duration;
				moving_q <= (h_c != '0);
				neg_q    <= diff_c[WORD_W];
				ta_q     <= '0;
				tc_q     <= '0;
				pk_q     <= '0;
				tf_q     <= '0;
				dacc_q   <= '0;
				ub_q     <= '0;
			end
			ST_VV: vv_q <= prod_q;
			ST_SQRT: begin
				if (done) ta_q <= sq_root_q;
			end
			ST_TRI_PK: begin
				pk_q <= (|prod_q[DWORD_W-1:FRAC_W+MAG_W]) ? MAG_MAX
					: prod_q[FRAC_W +: MAG_W];
			end
			ST_TRAP_DIV1: begin
				if (done) begin
					raw_q <= div_n_q;
					ta_q  <= (|div_n_q[DWORD_W-1:WORD_W]) ? '1 : div_n_q[WORD_W-1:0];
				end
			end
			ST_TRAP_DIV2: begin
				if (done) begin
					tc_q <= (|tdiff_c[DWORD_W-1:WORD_W]) ? '1 : tdiff_c[WORD_W-1:0];
					pk_q <= v_q;
				end
			end
			ST_TF: tf_q <= tf_c;
			ST_SY_DIV1: begin
				if (done) begin
					ta_q <= div_n_q[WORD_W-1:0];
					tc_q <= t_q - {div_n_q[WORD_W-2:0], 1'b0};
					tf_q <= {2'b00, t_q};
				end
			end
			ST_SY_DIV2: begin
				if (done) begin
					pk_q <= v2_c;
					if (ta_q == '0) ea_q <= MAG_W'(1);
				end
			end
			ST_SY_DIV3: begin
				if (done) ea_q <= (a2_c == '0) ? MAG_W'(1) : a2_c;
			end
			ST_FIN2: p_q <= prod_q;
			ST_FIN3: lo_q <= prod_q;
			ST_FIN4: dacc_q <= (prod_q + {{WORD_W{1'b0}}, lo_q[DWORD_W-1:WORD_W]}) >> 1;
			ST_FIN5: ub_q <= dacc_q + (prod_q >> FRAC_W);
			default: ;
		endcase
	end

	assign plan_ok     = (state_q == ST_DONE);
	assign plan.h      = h_q;
	assign plan.ta     = ta_q;
	assign plan.tc     = tc_q;
	assign plan.tf     = tf_q;
	assign plan.pk     = pk_q;
	assign plan.ea     = ea_q;
	assign plan.dacc   = dacc_q;
	assign plan.ub     = ub_q;
	assign plan.moving = moving_q;
	assign plan.neg    = neg_q;

endmodule
`default_nettype wire

FILE: rtl/trapezoidal_motion_profile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// Single-axis trapezoidal / triangular motion profile: position, velocity and
// acceleration in Q16.16 for each time sample word.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_write                 cfg_index, cfg_data
//   in        in         in_valid / in_stall       sample_time
//   out       out        out_valid / out_stall     position, velocity, acceleration
//
// One sample word per cycle through a six-stage pipeline while neither
// in_stall nor out_stall holds it. After reset or any register write the
// planner runs with in_stall high: a zero move goes straight to done, else
// it steps through its states on the shared radix-2 divider and a square root.
// Each stage holds its word while the next one is full and stalled, so a
// stall at the output loses and repeats nothing.
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile import tmp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [WORD_W-1:0]        cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [WORD_W-1:0]        sample_time,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [WORD_W-1:0]      position,
	output logic signed [WORD_W-1:0]      velocity,
	output logic signed [WORD_W-1:0]      acceleration
);

	logic [WORD_W-1:0] start_pos_q, end_pos_q, sync_dur_q;
	logic [MAG_W-1:0]  max_vel_q, max_acc_q;
	plan_t             plan;
	logic              plan_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_q <= '0;
			end_pos_q   <= '0;
			max_vel_q   <= MAG_W'(65536);
			max_acc_q   <= MAG_W'(65536);
			sync_dur_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_START_POS: start_pos_q <= cfg_data;
				REG_END_POS:   end_pos_q   <= cfg_data;
				REG_MAX_VEL:   max_vel_q   <= cfg_data[MAG_W-1:0];
				REG_MAX_ACC:   max_acc_q   <= cfg_data[MAG_W-1:0];
				REG_SYNC_DUR:  sync_dur_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	tmp_plan u_plan (
		.clk              (clk),
		.arst_n           (arst_n),
		.restart          (cfg_write),
		.start_position   (start_pos_q),
		.end_position     (end_pos_q),
		.max_velocity     (max_vel_q),
		.max_acceleration (max_acc_q),
		.sync_duration    (sync_dur_q),
		.plan             (plan),
		.plan_ok          (plan_ok)
	);

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic en1, en2, en3, en4, en5, en6;

	assign en6      = !out_valid || !out_stall;
	assign en5      = !v5_s5 || en6;
	assign en4      = !v4_s4 || en5;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_stall = !(en1 && plan_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			v5_s5     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_valid && plan_ok;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			if (en6) out_valid <= v5_s5;
		end
	end

	// stage 1: phase and time offset into the phase
	phase_t            ph_s1, ph_s2, ph_s3, ph_s4, ph_s5;
	logic [WORD_W-1:0] u_s1, u_s2;
	logic [WORD_W:0]   cru_end;

	assign cru_end = {1'b0, plan.ta} + {1'b0, plan.tc};

	always_ff @(posedge clk) begin
		if (en1) begin
			if (!plan.moving || sample_time == '0) begin
				ph_s1 <= PH_START;
				u_s1  <= '0;
			end else if ({2'b00, sample_time} >= plan.tf) begin
				ph_s1 <= PH_END;
				u_s1  <= '0;
			end else if (sample_time < plan.ta) begin
				ph_s1 <= PH_ACC;
				u_s1  <= sample_time;
			end else if ({1'b0, sample_time} < cru_end) begin
				ph_s1 <= PH_CRU;
				u_s1  <= sample_time - plan.ta;
			end else begin
				ph_s1 <= PH_DEC;
				u_s1  <= sample_time - plan.ta - plan.tc;
			end
		end
	end

	// stage 2: a*u and v*u
	logic [DWORD_W-2:0] p1_s2, p2_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			ph_s2 <= ph_s1;
			u_s2  <= u_s1;
			p1_s2 <= plan.ea * u_s1;
			p2_s2 <= plan.pk * u_s1;
		end
	end

	// stage 3: a*u*u partial products, velocity magnitude
	logic [DWORD_W-1:0]       mlo_s3;
	logic [DWORD_W-2:0]       mhi_s3;
	logic [DWORD_W-2-FRAC_W:0] dv_c;
	logic [DWORD_W-2-FRAC_W:0] p2s_s3, p2s_s4;
	logic [MAG_W-1:0]         vm_s3, vm_s4, vm_s5;

	assign dv_c = p1_s2[DWORD_W-2:FRAC_W];

	always_ff @(posedge clk) begin
		if (en3) begin
			ph_s3  <= ph_s2;
			mlo_s3 <= p1_s2[WORD_W-1:0] * u_s2;
			mhi_s3 <= p1_s2[DWORD_W-2:WORD_W] * u_s2;
			p2s_s3 <= p2_s2[DWORD_W-2:FRAC_W];
			case (ph_s2)
				PH_ACC: vm_s3 <= (dv_c > {{(DWORD_W-1-FRAC_W-MAG_W){1'b0}}, MAG_MAX})
					? MAG_MAX : dv_c[MAG_W-1:0];
				PH_CRU: vm_s3 <= plan.pk;
				PH_DEC: vm_s3 <= (dv_c < {{(DWORD_W-1-FRAC_W-MAG_W){1'b0}}, plan.pk})
					? (plan.pk - dv_c[MAG_W-1:0]) : '0;
				default: vm_s3 <= '0;
			endcase
		end
	end

	// stage 4: quadratic distance term, linear distance sum
	logic [DWORD_W-1:0] dq_s4, up_s4;
	logic [DWORD_W-1:0] dq_sum;

	assign dq_sum = {1'b0, mhi_s3} + {{WORD_W{1'b0}}, mlo_s3[DWORD_W-1:WORD_W]};

	always_ff @(posedge clk) begin
		if (en4) begin
			ph_s4 <= ph_s3;
			vm_s4 <= vm_s3;
			dq_s4 <= dq_sum >> 1;
			up_s4 <= ((ph_s3 == PH_CRU) ? plan.dacc : plan.ub)
				+ DWORD_W'(p2s_s3);
		end
	end

	// stage 5: travelled distance
	logic [DWORD_W-1:0] d_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			ph_s5 <= ph_s4;
			vm_s5 <= vm_s4;
			case (ph_s4)
				PH_ACC:  d_s5 <= dq_s4;
				PH_CRU:  d_s5 <= up_s4;
				PH_DEC:  d_s5 <= (up_s4 > dq_s4) ? (up_s4 - dq_s4) : '0;
				default: d_s5 <= '0;
			endcase
		end
	end

	// stage 6: clamp, direction, output word
	logic [WORD_W-1:0] dcl_c, vel_c, acc_mag_c;
	logic              acc_neg_c;

	assign dcl_c     = (d_s5 > DWORD_W'(plan.h)) ? plan.h : d_s5[WORD_W-1:0];
	assign vel_c     = {1'b0, vm_s5};
	assign acc_mag_c = (ph_s5 == PH_ACC || ph_s5 == PH_DEC) ? {1'b0, plan.ea} : '0;
	assign acc_neg_c = (ph_s5 == PH_DEC) ^ plan.neg;

	always_ff @(posedge clk) begin
		if (en6) begin
			case (ph_s5)
				PH_START: position <= start_pos_q;
				PH_END:   position <= end_pos_q;
				default:  position <= plan.neg ? (start_pos_q - dcl_c)
					: (start_pos_q + dcl_c);
			endcase
			velocity     <= plan.neg ? (~vel_c + 1'b1) : vel_c;
			acceleration <= acc_neg_c ? (~acc_mag_c + 1'b1) : acc_mag_c;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/tmp_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmp_chk
// Port-level checks for the motion profile generator, bound to the top level.
// ----------------------------------------------------------------------------
module tmp_chk import tmp_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cfg_write,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic [WORD_W-1:0]   sample_time,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [WORD_W-1:0]   position,
	input wire logic [WORD_W-1:0]   velocity,
	input wire logic [WORD_W-1:0]   acceleration
);

	localparam logic [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position))
		else $error("stalled output word changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample_time))
		else $error("stalled input word changed");

	a_replan: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> in_stall)
		else $error("sample accepted before replanning");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid && in_stall)
		else $error("handshake active in reset");

	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> velocity != MOST_NEG && acceleration != MOST_NEG)
		else $error("velocity or acceleration magnitude out of range");

endmodule

bind trapezoidal_motion_profile tmp_chk u_chk (.*);
`default_nettype wire
